// File: rtl/mlp_tanh_feedforward_core_macros.svh
// assertion helpers for the mlp tanh feedforward core
`ifndef MLP_TANH_FEEDFORWARD_CORE_MACROS_SVH
`define MLP_TANH_FEEDFORWARD_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtf check failed: same-cycle relation");

// next-cycle implication, checked outside reset
`define MTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtf check failed: next-cycle relation");

`endif

// File: rtl/mtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

  // data formats
  localparam int ACT_W          = 16;
  localparam int TANH_W         = 15;
  localparam int PWM_W          = 9;
  localparam int PWM_SCALE      = 255;
  localparam int TANH_MAX_DEPTH = 4096;

  // parameter defaults
  localparam int DEF_TANH_DEPTH  = 1024;
  localparam int DEF_WEIGHT_FRAC = 12;

  // network shape
  localparam int N_X  = 1;
  localparam int N_H1 = 3;
  localparam int N_H2 = 4;
  localparam int N_Y  = 1;

  // layer codes
  localparam int L_HID1 = 0;
  localparam int L_HID2 = 1;
  localparam int L_OUT  = 2;

  localparam logic signed [ACT_W-1:0] ACT_MAX = 16'sd32767;

  typedef logic signed [ACT_W-1:0]              act_t;
  typedef logic [TANH_MAX_DEPTH*TANH_W-1:0]    tanh_rom_t;

  // weights in units of 1e-8, last column is the bias
  localparam longint E8_SCALE = 64'sd100000000;
  localparam longint E8_HALF  = 64'sd50000000;

  localparam longint W1_E8 [N_H1][N_X+1] = '{
    '{-64'sd303455960, 64'sd290394588},
    '{-64'sd109763890, -64'sd70886087},
    '{-64'sd76857470,  -64'sd42865463}
  };

  localparam longint W2_E8 [N_H2][N_H1+1] = '{
    '{-64'sd68284827,  -64'sd21032326, -64'sd11784210, -64'sd2764689},
    '{-64'sd32831630,   64'sd18387903, -64'sd80329341,  64'sd94183746},
    '{-64'sd403018258,  64'sd55826217, -64'sd10950553, -64'sd24412867},
    '{-64'sd57183908,  -64'sd56724367,  64'sd50227013,  64'sd126036740}
  };

  localparam longint W3_E8 [N_H2+1] = '{
    64'sd5829049, 64'sd136496838, 64'sd220687278, 64'sd162508009, 64'sd29592965
  };

  // raw weight lookup, bias sits at input index n_in
  function automatic longint weight_e8(input int layer, input int o, input int i);
    longint w;
    w = 64'sd0;
    unique case (layer)
      L_HID1:  w = W1_E8[o][i];
      L_HID2:  w = W2_E8[o][i];
      default: w = W3_E8[i];
    endcase
    return w;
  endfunction

  // round half away from zero to fb fraction bits
  function automatic longint qweight(input longint v, input int fb);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q   = ((mag <<< fb) + E8_HALF) / E8_SCALE;
    return (v < 0) ? -q : q;
  endfunction

  // shift-subtract unsigned divide for table generation
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh magnitude table: entry k covers |x| in [4k/depth, 4(k+1)/depth)
  function automatic tanh_rom_t build_tanh_rom(input int depth);
    tanh_rom_t   rom;
    logic [63:0] one;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] t;
    logic [63:0] cu;
    longint      c;
    rom  = '0;
    one  = 64'd1 << 32;
    term = one;
    e    = one;
    c    = longint'(one);
    // c = exp(-8/depth) by truncated series
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(term * 64'd8, 64'(depth) * 64'(n));
      if (n[0]) begin
        c = c - longint'(term);
      end else begin
        c = c + longint'(term);
      end
    end
    if (c < 0) begin
      c = 0;
    end
    if (c >= longint'(one)) begin
      c = longint'(one) - 1;
    end
    cu = 64'(c);
    for (int k = 0; k < depth; k++) begin
      num = (one - e) << 15;
      den = one + e;
      t   = udiv64(num + (den >> 1), den);
      if (t > 64'd32767) begin
        t = 64'd32767;
      end
      rom[k*TANH_W +: TANH_W] = t[TANH_W-1:0];
      e = (e * cu) >> 32;
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mtf_tanh_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module mtf_tanh_rom #(
  parameter int TANH_TABLE_DEPTH = mtf_pkg::DEF_TANH_DEPTH,
  parameter logic [TANH_TABLE_DEPTH*mtf_pkg::TANH_W-1:0] TANH_ROM = '0
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [$clog2(TANH_TABLE_DEPTH)-1:0] addr_i,
  output logic      [mtf_pkg::TANH_W-1:0]          data_o
);

  logic [mtf_pkg::TANH_W-1:0] data_q;

  // registered table read, held while the pipeline is frozen
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= TANH_ROM[addr_i * mtf_pkg::TANH_W +: mtf_pkg::TANH_W];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: rtl/mtf_layer.sv
`timescale 1ns / 1ps
`default_nettype none

module mtf_layer #(
  parameter int LAYER            = mtf_pkg::L_HID1,
  parameter int N_IN             = mtf_pkg::N_X,
  parameter int N_OUT            = mtf_pkg::N_H1,
  parameter int WEIGHT_FRAC_BITS = mtf_pkg::DEF_WEIGHT_FRAC,
  parameter int TANH_TABLE_DEPTH = mtf_pkg::DEF_TANH_DEPTH,
  parameter logic [TANH_TABLE_DEPTH*mtf_pkg::TANH_W-1:0] TANH_ROM = '0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire mtf_pkg::act_t act_i [N_IN],
  output logic               valid_o,
  output mtf_pkg::act_t      act_o [N_OUT]
);

  localparam int W_W    = WEIGHT_FRAC_BITS + 4;
  localparam int P_W    = mtf_pkg::ACT_W + W_W;
  localparam int ACC_W  = WEIGHT_FRAC_BITS + 19;
  localparam int FRAC_W = WEIGHT_FRAC_BITS + 17;
  localparam int IDX_W  = $clog2(TANH_TABLE_DEPTH);
  localparam int SCL_W  = FRAC_W + IDX_W + 1;
  localparam int NSTG   = 4;

  logic [NSTG-1:0] vld_q;

  // valid bits: product, sum, index, table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NSTG-1];

  for (genvar o = 0; o < N_OUT; o++) begin : g_neuron
    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(
      mtf_pkg::qweight(mtf_pkg::weight_e8(LAYER, o, N_IN), WEIGHT_FRAC_BITS) * 64'sd32768);

    logic signed [W_W-1:0]           wgt    [N_IN];
    logic signed [P_W-1:0]           prod_q [N_IN];
    logic signed [ACC_W-1:0]         acc_d;
    logic signed [ACC_W-1:0]         acc_q;
    logic        [ACC_W-1:0]         mag;
    logic        [SCL_W-1:0]         scaled;
    logic        [IDX_W-1:0]         idx_d;
    logic        [IDX_W-1:0]         idx_q;
    logic                            sat_d;
    logic                            sat_q;
    logic                            neg_q;
    logic                            sat4_q;
    logic                            neg4_q;
    logic        [mtf_pkg::TANH_W-1:0] rom_data;
    logic signed [mtf_pkg::ACT_W-1:0]  act_mag;

    // quantized weights
    for (genvar i = 0; i < N_IN; i++) begin : g_wgt
      assign wgt[i] = W_W'(
        mtf_pkg::qweight(mtf_pkg::weight_e8(LAYER, o, i), WEIGHT_FRAC_BITS));
    end

    // weighted sum plus bias
    always_comb begin
      acc_d = BIAS;
      for (int i = 0; i < N_IN; i++) begin
        acc_d = acc_d + ACC_W'(prod_q[i]);
      end
    end

    // magnitude, saturation and table index
    always_comb begin
      mag    = acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
      sat_d  = |mag[ACC_W-1:FRAC_W];
      scaled = SCL_W'(mag[FRAC_W-1:0]) * SCL_W'(TANH_TABLE_DEPTH);
      idx_d  = scaled[FRAC_W +: IDX_W];
    end

    // datapath stages
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < N_IN; i++) begin
          prod_q[i] <= P_W'(act_i[i]) * P_W'(wgt[i]);
        end
        acc_q  <= acc_d;
        idx_q  <= idx_d;
        sat_q  <= sat_d;
        neg_q  <= acc_q[ACC_W-1];
        sat4_q <= sat_q;
        neg4_q <= neg_q;
      end
    end

    mtf_tanh_rom #(
      .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH),
      .TANH_ROM        (TANH_ROM)
    ) u_rom (
      .clk_i (clk_i),
      .en_i  (en_i),
      .addr_i(idx_q),
      .data_o(rom_data)
    );

    // apply saturation and sign
    assign act_mag  = sat4_q ? mtf_pkg::ACT_MAX : $signed({1'b0, rom_data});
    assign act_o[o] = neg4_q ? -act_mag : act_mag;
  end

endmodule

`default_nettype wire

// File: rtl/mlp_tanh_feedforward_core.sv
// throughput: one request per cycle while no held result is stalled
// 13 register stages (4 per layer, 1 output), the first loads at the accepting edge
// each layer is a product, sum, index, table-read pipe
// a stall on the output freezes every stage in place; bubbles are not squeezed out
// reset clears the valid bits only; the tanh table is constant logic, no fill after reset
`timescale 1ns / 1ps
`default_nettype none
`include "mlp_tanh_feedforward_core_macros.svh"

module mlp_tanh_feedforward_core #(
  parameter int TANH_TABLE_DEPTH = mtf_pkg::DEF_TANH_DEPTH,
  parameter int WEIGHT_FRAC_BITS = mtf_pkg::DEF_WEIGHT_FRAC
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [mtf_pkg::ACT_W-1:0] setpoint_norm_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [mtf_pkg::ACT_W-1:0]      net_output_o,
  output logic signed [mtf_pkg::PWM_W-1:0]      drive_pwm_o
);

  localparam int ROM_BITS_W = TANH_TABLE_DEPTH * mtf_pkg::TANH_W;
  localparam mtf_pkg::tanh_rom_t TANH_FULL = mtf_pkg::build_tanh_rom(TANH_TABLE_DEPTH);
  localparam logic [ROM_BITS_W-1:0] TANH_ROM = TANH_FULL[ROM_BITS_W-1:0];
  localparam int PROD_W = mtf_pkg::TANH_W + 8;

  logic          en;
  logic          h1_valid;
  logic          h2_valid;
  logic          y_valid;
  mtf_pkg::act_t x_act  [mtf_pkg::N_X];
  mtf_pkg::act_t h1_act [mtf_pkg::N_H1];
  mtf_pkg::act_t h2_act [mtf_pkg::N_H2];
  mtf_pkg::act_t y_act  [mtf_pkg::N_Y];

  logic                              out_valid_q;
  logic signed [mtf_pkg::ACT_W-1:0]  net_output_q;
  logic signed [mtf_pkg::PWM_W-1:0]  drive_pwm_q;
  logic signed [mtf_pkg::PWM_W-1:0]  drive_d;
  logic        [mtf_pkg::ACT_W-1:0]  y_mag;
  logic        [PROD_W-1:0]          y_scaled;
  logic        [mtf_pkg::PWM_W-1:0]  drv_mag;

  // whole pipeline advances unless a held result is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign x_act[0]   = setpoint_norm_i;

  mtf_layer #(
    .LAYER           (mtf_pkg::L_HID1),
    .N_IN            (mtf_pkg::N_X),
    .N_OUT           (mtf_pkg::N_H1),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH),
    .TANH_ROM        (TANH_ROM)
  ) u_hid1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .act_i  (x_act),
    .valid_o(h1_valid),
    .act_o  (h1_act)
  );

  mtf_layer #(
    .LAYER           (mtf_pkg::L_HID2),
    .N_IN            (mtf_pkg::N_H1),
    .N_OUT           (mtf_pkg::N_H2),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH),
    .TANH_ROM        (TANH_ROM)
  ) u_hid2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(h1_valid),
    .act_i  (h1_act),
    .valid_o(h2_valid),
    .act_o  (h2_act)
  );

  mtf_layer #(
    .LAYER           (mtf_pkg::L_OUT),
    .N_IN            (mtf_pkg::N_H2),
    .N_OUT           (mtf_pkg::N_Y),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH),
    .TANH_ROM        (TANH_ROM)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(h2_valid),
    .act_i  (h2_act),
    .valid_o(y_valid),
    .act_o  (y_act)
  );

  // drive value: magnitude times 255, truncated, sign restored
  always_comb begin
    y_mag    = y_act[0][mtf_pkg::ACT_W-1] ? $unsigned(-y_act[0]) : $unsigned(y_act[0]);
    y_scaled = PROD_W'(y_mag[mtf_pkg::TANH_W-1:0]) * PROD_W'(mtf_pkg::PWM_SCALE);
    drv_mag  = {1'b0, y_scaled[PROD_W-1:mtf_pkg::TANH_W]};
    drive_d  = y_act[0][mtf_pkg::ACT_W-1] ? -$signed(drv_mag) : $signed(drv_mag);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= y_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      net_output_q <= y_act[0];
      drive_pwm_q  <= drive_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign net_output_o = net_output_q;
  assign drive_pwm_o  = drive_pwm_q;

  // tanh output never reaches minus one, drive stays within +-255
  `MTF_ASSERT_NOW(a_out_range, clk_i, rst_ni, out_valid_o,
    (net_output_o != 16'sh8000) && (drive_pwm_o != -9'sd256))
  // a non-negative network output never gives a negative drive
  `MTF_ASSERT_NOW(a_drive_sign, clk_i, rst_ni, out_valid_o && !net_output_o[15],
    !drive_pwm_o[8])
  // a frozen pipeline keeps its inner valid bits
  `MTF_ASSERT_NEXT(a_freeze, clk_i, rst_ni, in_stall_o,
    $stable(h1_valid) && $stable(h2_valid) && $stable(y_valid))

endmodule

`default_nettype wire

// File: test/mlp_tanh_feedforward_checker.sv
`timescale 1ns / 1ps

module mlp_tanh_feedforward_checker #(
  parameter int TANH_DEPTH = 1024,
  parameter int W_FRAC     = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  mtf_pkg::act_t                       setpoint_norm_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  mtf_pkg::act_t                       net_output_i,
  input  logic signed [mtf_pkg::PWM_W-1:0]    drive_pwm_i,
  output int                                  fail_cnt_o,
  output int                                  pending_o
);

  typedef struct packed {
    mtf_pkg::act_t                    net;
    logic signed [mtf_pkg::PWM_W-1:0] pwm;
  } drive_result_t;

  // network weights in units of 1e-8, bias in the last column
  longint hid1_w [3][2] = '{
    '{-64'sd303455960, 64'sd290394588},
    '{-64'sd109763890, -64'sd70886087},
    '{-64'sd76857470, -64'sd42865463}
  };
  longint hid2_w [4][4] = '{
    '{-64'sd68284827, -64'sd21032326, -64'sd11784210, -64'sd2764689},
    '{-64'sd32831630, 64'sd18387903, -64'sd80329341, 64'sd94183746},
    '{-64'sd403018258, 64'sd55826217, -64'sd10950553, -64'sd24412867},
    '{-64'sd57183908, -64'sd56724367, 64'sd50227013, 64'sd126036740}
  };
  longint out_w [5] = '{
    64'sd5829049, 64'sd136496838, 64'sd220687278, 64'sd162508009, 64'sd29592965
  };

  // tanh magnitude per table step of 4/TANH_DEPTH
  int tanh_mag [TANH_DEPTH];

  drive_result_t net_results_q [$];

  // decimal weight to fixed point, half away from zero
  function automatic longint to_fixed(input longint v);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q   = ((mag <<< W_FRAC) + 64'sd50000000) / 64'sd100000000;
    return (v < 0) ? -q : q;
  endfunction

  // sum with 15 + W_FRAC fraction bits to signed Q1.15 activation
  function automatic int tanh_lookup(input longint acc);
    longint mag;
    longint idx;
    int     t;
    mag = (acc < 0) ? -acc : acc;
    idx = (mag * TANH_DEPTH) >>> (W_FRAC + 17);
    t   = (idx >= TANH_DEPTH) ? 32767 : tanh_mag[idx];
    return (acc < 0) ? -t : t;
  endfunction

  // full forward pass for one setpoint
  function automatic drive_result_t mlp_forward(input mtf_pkg::act_t sp);
    longint        acc;
    int            h1 [3];
    int            h2 [4];
    int            y;
    int            mag;
    int            drv;
    drive_result_t r;
    for (int i = 0; i < 3; i++) begin
      acc   = longint'(sp) * hid1_w[i][0] + hid1_w[i][1] * 32768;
      h1[i] = tanh_lookup(acc);
    end
    for (int i = 0; i < 4; i++) begin
      acc = hid2_w[i][3] * 32768;
      for (int j = 0; j < 3; j++) begin
        acc += longint'(h1[j]) * hid2_w[i][j];
      end
      h2[i] = tanh_lookup(acc);
    end
    acc = out_w[4] * 32768;
    for (int j = 0; j < 4; j++) begin
      acc += longint'(h2[j]) * out_w[j];
    end
    y     = tanh_lookup(acc);
    mag   = (y < 0) ? -y : y;
    drv   = (mag * 255) >> 15;
    drv   = (y < 0) ? -drv : drv;
    r.net = y[15:0];
    r.pwm = drv[mtf_pkg::PWM_W-1:0];
    return r;
  endfunction

  // quantize weights and build the tanh table once
  initial begin : build_tables
    longint unsigned unity;
    longint unsigned term;
    longint unsigned decay_u;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned t;
    longint          decay;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        hid1_w[i][j] = to_fixed(hid1_w[i][j]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        hid2_w[i][j] = to_fixed(hid2_w[i][j]);
      end
    end
    for (int j = 0; j < 5; j++) begin
      out_w[j] = to_fixed(out_w[j]);
    end
    // per-step decay exp(-8/depth) by truncated series in Q0.32
    unity = 64'd1 << 32;
    term  = unity;
    decay = longint'(unity);
    for (int n = 1; n <= 12; n++) begin
      term = (term * 64'd8) / (longint'(TANH_DEPTH) * longint'(n));
      if (n % 2 == 1) begin
        decay = decay - longint'(term);
      end else begin
        decay = decay + longint'(term);
      end
    end
    if (decay < 0) begin
      decay = 0;
    end
    if (decay >= longint'(unity)) begin
      decay = longint'(unity) - 1;
    end
    decay_u = decay;
    e       = unity;
    for (int k = 0; k < TANH_DEPTH; k++) begin
      num = (unity - e) << 15;
      den = unity + e;
      t   = (num + den / 2) / den;
      if (t > 64'd32767) begin
        t = 64'd32767;
      end
      tanh_mag[k] = int'(t);
      e = (e * decay_u) >> 32;
    end
  end

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  // record each accepted request, compare each accepted result
  always @(posedge clk_i) begin : watch_ports
    drive_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        net_results_q.push_back(mlp_forward(setpoint_norm_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (net_results_q.size() == 0) begin
          $error("unexpected result: net_output %0d, drive_pwm %0d",
                 net_output_i, drive_pwm_i);
          fail_cnt_o++;
        end else begin
          want = net_results_q.pop_front();
          if (net_output_i !== want.net) begin
            $error("net_output mismatch: expected %0d, actual %0d",
                   $signed(want.net), net_output_i);
            fail_cnt_o++;
          end
          if (drive_pwm_i !== want.pwm) begin
            $error("drive_pwm mismatch: expected %0d, actual %0d",
                   $signed(want.pwm), drive_pwm_i);
            fail_cnt_o++;
          end
        end
      end
      pending_o <= net_results_q.size();
    end
  end

endmodule

// File: test/mlp_tanh_feedforward_core_tb.sv
`timescale 1ns / 1ps

module mlp_tanh_feedforward_core_tb;

  localparam int PHASE_ITEMS  = 376;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 400000;

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             in_valid_i      = 1'b0;
  mtf_pkg::act_t                    setpoint_norm_i = '0;
  logic                             out_stall_i     = 1'b0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  mtf_pkg::act_t                    net_output_o;
  logic signed [mtf_pkg::PWM_W-1:0] drive_pwm_o;

  int fail_cnt;
  int pending_cnt;
  int cycle_cnt      = 0;
  int send_idle_pct  = 8;
  int recv_stall_pct = 79;
  int stage          = 0;

  // full scale, saturation region, sign boundaries, bit patterns
  int corner_vals [22] = '{
    -32768, 32767, 0, -1, 1, 16384, -16384, 8192, -8192, 21845, -21846,
    1000, -1000, 4096, -4096, 24576, -24576, 31000, -31000, 100, -100, 12000
  };

  mlp_tanh_feedforward_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .setpoint_norm_i (setpoint_norm_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .net_output_o    (net_output_o),
    .drive_pwm_o     (drive_pwm_o)
  );

  mlp_tanh_feedforward_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .setpoint_norm_i (setpoint_norm_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .net_output_i    (net_output_o),
    .drive_pwm_i     (drive_pwm_o),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending_cnt)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("mlp_tanh_feedforward_core_tb NOT OK");
      $finish;
    end
  end

  // half full range, half near zero where the curve bends
  function automatic mtf_pkg::act_t pick_setpoint();
    if ($urandom_range(1) == 0) begin
      return mtf_pkg::act_t'($urandom_range(65535));
    end
    return mtf_pkg::act_t'(int'($urandom_range(8191)) - 4096);
  endfunction

  // one request, with random idle cycles before it
  task automatic offer_setpoint(input mtf_pkg::act_t sp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    setpoint_norm_i <= sp;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  // result side: random stalls, one long hold-off when stalls stop
  initial begin : recv_side
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stage == 2 && !held_off) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // request side and verdict
  initial begin : send_side
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_vals[i]) begin
      offer_setpoint(mtf_pkg::act_t'(corner_vals[i]));
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      offer_setpoint(pick_setpoint());
    end

    send_idle_pct  = 79;
    recv_stall_pct = 8;
    stage          = 1;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      offer_setpoint(pick_setpoint());
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stage          = 2;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      offer_setpoint(pick_setpoint());
    end

    // drain
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("mlp_tanh_feedforward_core_tb OK");
    end else begin
      $display("mlp_tanh_feedforward_core_tb NOT OK");
    end
    $finish;
  end

endmodule
